// ===== sv/eabv_pkg.sv =====
// Shared types, constants and elaboration helpers for the Euler-angle basis block.
package eabv_pkg;

    localparam int PHASE_W = 32;   // binary angle, one turn = 2^32
    localparam int CORD_W  = 34;   // CORDIC datapath, Q2.30 with headroom
    localparam int SC_W    = 32;   // sine / cosine, Q2.30
    localparam int PROD_W  = 64;   // products and sums, Q60
    localparam int N_RES = 9;

    localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;

    // atan(2^-i) in binary angle units
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic en;    // pipeline advances
        logic vld;   // request present at this stage's input
    } t_ctl;

    // number of conditional subtractions of turn*2^j needed to bring umax below turn
    function automatic int red_steps(input int turn, input int umax);
        int s;
        s = 0;
        while ((turn << s) <= umax) s++;
        return s;
    endfunction

endpackage

// ===== sv/eabv_phase.sv =====
// Angle lane front end: reduce the angle modulo a turn and map it to a 32-bit binary angle.
module eabv_phase #(
    parameter int ANGLE_FRAC_BITS = 6
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  eabv_pkg::t_ctl                 i_ctl,
    input  logic signed [15:0]             i_angle,
    output logic                           o_vld,
    output logic [eabv_pkg::PHASE_W-1:0]   o_phase
);
    localparam int DEG_TURN  = 360;
    localparam int TURN      = DEG_TURN << ANGLE_FRAC_BITS;
    localparam int HALF_TURN = TURN / 2;
    localparam int NOFF      = (32768 + TURN - 1) / TURN;
    localparam int OFF       = NOFF * TURN;
    localparam int UMAX      = 32767 + OFF;
    localparam int UW        = $clog2(UMAX + 1);
    localparam int RW        = $clog2(TURN);
    localparam int RSTEPS    = eabv_pkg::red_steps(TURN, UMAX);
    localparam int PW        = eabv_pkg::PHASE_W;
    // 2^32 = Q0 * turn + R0
    localparam longint BA_TURN = longint'(1) << PW;
    localparam longint Q0      = BA_TURN / TURN;
    localparam longint R0      = BA_TURN % TURN;
    localparam int     QW      = $clog2(Q0 + 1);
    localparam int     MFW     = 2 * RW;
    localparam longint MMAX    = ((longint'(TURN) - 1) * R0 + HALF_TURN) >>> ANGLE_FRAC_BITS;
    localparam int     MW      = $clog2(MMAX + 1);
    localparam int     KSH     = MW + $clog2(DEG_TURN);
    localparam longint RECIP   = ((longint'(1) << KSH) + DEG_TURN - 1) / DEG_TURN;
    localparam int     CW      = $clog2(RECIP + 1);
    localparam int     XW      = MW + CW;
    localparam logic [QW-1:0]  Q0_V    = QW'(Q0);
    localparam logic [MFW-1:0] R0_V    = MFW'(R0);
    localparam logic [MFW-1:0] HALF_V  = MFW'(HALF_TURN);
    localparam logic [CW-1:0]  RECIP_V = CW'(RECIP);

    logic signed [UW:0] w_sum;
    logic [UW-1:0]      n_red;
    logic [RW+QW-1:0]   w_hi;
    logic [MFW-1:0]     w_mfull;
    logic [XW-1:0]      w_qp;
    logic               r_vld [0:3];
    logic [RW-1:0]      r_a;
    logic [PW-1:0]      r_hi1, r_hi2, r_phase;
    logic [MW-1:0]      r_m;
    logic [XW-1:0]      r_qp;

    // offset by a whole number of turns so the value is never negative
    assign w_sum = (UW+1)'(i_angle) + (UW+1)'(OFF);

    always_comb begin
        n_red = w_sum[UW-1:0];
        for (int j = RSTEPS - 1; j >= 0; j--) begin
            if (n_red >= UW'(TURN << j)) n_red = n_red - UW'(TURN << j);
        end
    end

    // (a*2^32 + turn/2) / turn = a*Q0 + ((a*R0 + turn/2) >> frac) / 360,
    // the last division by reciprocal multiplication, exact over the whole range
    assign w_hi    = {{QW{1'b0}}, r_a} * {{RW{1'b0}}, Q0_V};
    assign w_mfull = {{RW{1'b0}}, r_a} * R0_V + HALF_V;
    assign w_qp    = {{CW{1'b0}}, r_m} * {{MW{1'b0}}, RECIP_V};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= 3; k++) r_vld[k] <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld[0] <= i_ctl.vld;
            for (int k = 1; k <= 3; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_a     <= n_red[RW-1:0];
            r_hi1   <= w_hi[PW-1:0];
            r_m     <= w_mfull[ANGLE_FRAC_BITS +: MW];
            r_hi2   <= r_hi1;
            r_qp    <= w_qp;
            r_phase <= r_hi2 + PW'(r_qp >> KSH);
        end
    end

    assign o_vld   = r_vld[3];
    assign o_phase = r_phase;

endmodule

// ===== sv/eabv_cordic.sv =====
// Angle lane back end: quadrant fold and pipelined rotation-mode CORDIC giving sine and cosine.
module eabv_cordic #(
    parameter int SINCOS_STAGES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  eabv_pkg::t_ctl                      i_ctl,
    input  logic [eabv_pkg::PHASE_W-1:0]        i_phase,
    output logic                                o_vld,
    output logic signed [eabv_pkg::SC_W-1:0]    o_sin,
    output logic signed [eabv_pkg::SC_W-1:0]    o_cos
);
    localparam int N  = SINCOS_STAGES;
    localparam int CW = eabv_pkg::CORD_W;
    localparam int PW = eabv_pkg::PHASE_W;

    logic [PW-1:0]        w_padd;
    logic                 w_flip;
    logic [PW-1:0]        w_pf;
    logic signed [CW-1:0] r_x  [1:N];
    logic signed [CW-1:0] r_y  [1:N];
    logic signed [CW-1:0] r_z  [0:N];
    logic                 r_flip [0:N];
    logic                 r_vld  [0:N];
    logic                 r_ovld;
    logic signed [eabv_pkg::SC_W-1:0] r_sin, r_cos;

    // phases in [90,270) deg are turned half a turn; results negated at the end
    assign w_padd = i_phase + 32'h4000_0000;
    assign w_flip = w_padd[PW-1];
    assign w_pf   = w_flip ? i_phase + 32'h8000_0000 : i_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld[0] <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_z[0]    <= CW'($signed(w_pf));
            r_flip[0] <= w_flip;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        localparam int K = i % 32;
        logic signed [CW-1:0] w_xi, w_yi;
        logic signed [CW-1:0] n_x, n_y, n_z;
        logic signed [CW-1:0] w_at;

        if (i == 0) begin : g_first
            assign w_xi = eabv_pkg::CORDIC_GAIN;
            assign w_yi = '0;
        end else begin : g_rest
            assign w_xi = r_x[i];
            assign w_yi = r_y[i];
        end

        assign w_at = $signed({2'b00, eabv_pkg::ATAN_TAB[K]});

        always_comb begin
            if (!r_z[i][CW-1]) begin
                n_x = w_xi - (w_yi >>> K);
                n_y = w_yi + (w_xi >>> K);
                n_z = r_z[i] - w_at;
            end else begin
                n_x = w_xi + (w_yi >>> K);
                n_y = w_yi - (w_xi >>> K);
                n_z = r_z[i] + w_at;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld[i+1] <= r_vld[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_x[i+1]    <= n_x;
                r_y[i+1]    <= n_y;
                r_z[i+1]    <= n_z;
                r_flip[i+1] <= r_flip[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_ctl.en) begin
            r_ovld <= r_vld[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            if (r_flip[N]) begin
                r_sin <= eabv_pkg::SC_W'(-r_y[N]);
                r_cos <= eabv_pkg::SC_W'(-r_x[N]);
            end else begin
                r_sin <= eabv_pkg::SC_W'(r_y[N]);
                r_cos <= eabv_pkg::SC_W'(r_x[N]);
            end
        end
    end

    assign o_vld = r_ovld;
    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

// ===== sv/eabv_merge.sv =====
// Merge stage: combines the three lanes' sines and cosines into the basis vector components.
module eabv_merge #(
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  eabv_pkg::t_ctl                      i_ctl,
    input  logic signed [eabv_pkg::SC_W-1:0]    i_sp,
    input  logic signed [eabv_pkg::SC_W-1:0]    i_cp,
    input  logic signed [eabv_pkg::SC_W-1:0]    i_sy,
    input  logic signed [eabv_pkg::SC_W-1:0]    i_cy,
    input  logic signed [eabv_pkg::SC_W-1:0]    i_sr,
    input  logic signed [eabv_pkg::SC_W-1:0]    i_cr,
    output logic                                o_vld,
    output logic signed [OUT_FRAC_BITS+1:0]     o_res [eabv_pkg::N_RES]
);
    localparam int OW = OUT_FRAC_BITS + 2;
    localparam int XW = eabv_pkg::PROD_W;
    localparam int SW = eabv_pkg::SC_W;
    localparam int NR = eabv_pkg::N_RES;
    localparam int SH = 60 - OUT_FRAC_BITS;
    localparam logic signed [XW-1:0] RND = XW'(64'sd1 <<< (SH - 1));
    localparam logic signed [XW-1:0] LIM = XW'(64'sd1 <<< OUT_FRAC_BITS);
    localparam logic signed [XW-1:0] RND30 = 64'sd536870912;

    logic                 r_vld [1:5];

    // first products
    logic signed [XW-1:0] r1_cpcy, r1_cpsy, r1_srcp, r1_crcp, r1_crsy;
    logic signed [XW-1:0] r1_srsy, r1_crcy, r1_srcy, r1_srsp, r1_crsp;
    logic signed [SW-1:0] r1_sp, r1_sy, r1_cy;
    // rounded pitch-roll pairs
    logic signed [SW-1:0] r2_srsp, r2_crsp, r2_sp, r2_sy, r2_cy;
    logic signed [XW-1:0] r2_cpcy, r2_cpsy, r2_srcp, r2_crcp, r2_crsy;
    logic signed [XW-1:0] r2_srsy, r2_crcy, r2_srcy;
    // three-factor terms
    logic signed [XW-1:0] r3_srspcy, r3_srspsy, r3_crspcy, r3_crspsy;
    logic signed [XW-1:0] r3_cpcy, r3_cpsy, r3_srcp, r3_crcp, r3_crsy;
    logic signed [XW-1:0] r3_srsy, r3_crcy, r3_srcy;
    logic signed [SW-1:0] r3_sp;
    // Q60 sums
    logic signed [XW-1:0] n_q [NR];
    logic signed [XW-1:0] r_q [NR];
    logic signed [OW-1:0] n_res [NR];
    logic signed [OW-1:0] r_res [NR];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= 5; k++) r_vld[k] <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld[1] <= i_ctl.vld;
            for (int k = 2; k <= 5; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r1_cpcy <= i_cp * i_cy;
            r1_cpsy <= i_cp * i_sy;
            r1_srcp <= i_sr * i_cp;
            r1_crcp <= i_cr * i_cp;
            r1_crsy <= i_cr * i_sy;
            r1_srsy <= i_sr * i_sy;
            r1_crcy <= i_cr * i_cy;
            r1_srcy <= i_sr * i_cy;
            r1_srsp <= i_sr * i_sp;
            r1_crsp <= i_cr * i_sp;
            r1_sp   <= i_sp;
            r1_sy   <= i_sy;
            r1_cy   <= i_cy;

            r2_srsp <= SW'((r1_srsp + RND30) >>> 30);
            r2_crsp <= SW'((r1_crsp + RND30) >>> 30);
            r2_sp   <= r1_sp;
            r2_sy   <= r1_sy;
            r2_cy   <= r1_cy;
            r2_cpcy <= r1_cpcy;
            r2_cpsy <= r1_cpsy;
            r2_srcp <= r1_srcp;
            r2_crcp <= r1_crcp;
            r2_crsy <= r1_crsy;
            r2_srsy <= r1_srsy;
            r2_crcy <= r1_crcy;
            r2_srcy <= r1_srcy;

            r3_srspcy <= r2_srsp * r2_cy;
            r3_srspsy <= r2_srsp * r2_sy;
            r3_crspcy <= r2_crsp * r2_cy;
            r3_crspsy <= r2_crsp * r2_sy;
            r3_cpcy   <= r2_cpcy;
            r3_cpsy   <= r2_cpsy;
            r3_srcp   <= r2_srcp;
            r3_crcp   <= r2_crcp;
            r3_crsy   <= r2_crsy;
            r3_srsy   <= r2_srsy;
            r3_crcy   <= r2_crcy;
            r3_srcy   <= r2_srcy;
            r3_sp     <= r2_sp;

            r_q   <= n_q;
            r_res <= n_res;
        end
    end

    always_comb begin
        n_q[0] = r3_cpcy;
        n_q[1] = r3_cpsy;
        n_q[2] = -(XW'(r3_sp) <<< 30);
        n_q[3] = r3_crsy - r3_srspcy;
        n_q[4] = -r3_srspsy - r3_crcy;
        n_q[5] = -r3_srcp;
        n_q[6] = r3_crspcy + r3_srsy;
        n_q[7] = r3_crspsy - r3_srcy;
        n_q[8] = r3_crcp;
    end

    // round half up to the output scale, then clamp to unity
    always_comb begin
        logic signed [XW-1:0] v;
        v = '0;
        for (int k = 0; k < NR; k++) begin
            v = (r_q[k] + RND) >>> SH;
            if (v > LIM)       v = LIM;
            else if (v < -LIM) v = -LIM;
            n_res[k] = OW'(v);
        end
    end

    assign o_vld = r_vld[5];
    assign o_res = r_res;

endmodule

// ===== sv/euler_angles_to_basis_vectors.sv =====
// Top level: Euler angles to forward, right and up basis vectors.
// Takes one orientation (pitch, yaw, roll) per cycle and returns the three direction
// vectors in Q1.OUT_FRAC_BITS, one result per request, in order. The pipeline runs
// through the turn reduction and phase mapping, the quadrant fold, SINCOS_STAGES
// CORDIC steps, the sign restore and five product and rounding stages. The three
// angles run in parallel lanes that each hold a turn reduction, a reciprocal-multiply
// phase mapping and an unrolled CORDIC; the whole pipeline moves together and only
// halts while a finished result sits unclaimed at the output with the downstream not
// ready.
module euler_angles_to_basis_vectors #(
    parameter int ANGLE_FRAC_BITS = 6,
    parameter int OUT_FRAC_BITS   = 14,
    parameter int SINCOS_STAGES   = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [15:0]           i_pitch_angle,
    input  logic signed [15:0]           i_yaw_angle,
    input  logic signed [15:0]           i_roll_angle,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [OUT_FRAC_BITS+1:0] o_forward_x,
    output logic signed [OUT_FRAC_BITS+1:0] o_forward_y,
    output logic signed [OUT_FRAC_BITS+1:0] o_forward_z,
    output logic signed [OUT_FRAC_BITS+1:0] o_right_x,
    output logic signed [OUT_FRAC_BITS+1:0] o_right_y,
    output logic signed [OUT_FRAC_BITS+1:0] o_right_z,
    output logic signed [OUT_FRAC_BITS+1:0] o_up_x,
    output logic signed [OUT_FRAC_BITS+1:0] o_up_y,
    output logic signed [OUT_FRAC_BITS+1:0] o_up_z
);
    localparam int OW = OUT_FRAC_BITS + 2;

    logic                                 w_en;
    eabv_pkg::t_ctl                       w_in_ctl;
    eabv_pkg::t_ctl                       w_cd_ctl [3];
    eabv_pkg::t_ctl                       w_mg_ctl;
    logic signed [15:0]                   w_angle [3];
    logic                                 w_ph_vld [3];
    logic [eabv_pkg::PHASE_W-1:0]         w_phase [3];
    logic                                 w_sc_vld [3];
    logic signed [eabv_pkg::SC_W-1:0]     w_sin [3];
    logic signed [eabv_pkg::SC_W-1:0]     w_cos [3];
    logic signed [OW-1:0]                 w_res [eabv_pkg::N_RES];

    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;
    assign w_in_ctl   = '{en: w_en, vld: i_in_valid};

    assign w_angle[0] = i_pitch_angle;
    assign w_angle[1] = i_yaw_angle;
    assign w_angle[2] = i_roll_angle;

    for (genvar l = 0; l < 3; l++) begin : g_lane
        assign w_cd_ctl[l] = '{en: w_en, vld: w_ph_vld[l]};

        eabv_phase #(
            .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
        ) u_phase (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_in_ctl),
            .i_angle (w_angle[l]),
            .o_vld   (w_ph_vld[l]),
            .o_phase (w_phase[l])
        );

        eabv_cordic #(
            .SINCOS_STAGES(SINCOS_STAGES)
        ) u_cordic (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_cd_ctl[l]),
            .i_phase (w_phase[l]),
            .o_vld   (w_sc_vld[l]),
            .o_sin   (w_sin[l]),
            .o_cos   (w_cos[l])
        );
    end

    // lanes run in lock step, so their valids agree
    assign w_mg_ctl = '{en: w_en, vld: w_sc_vld[0] && w_sc_vld[1] && w_sc_vld[2]};

    eabv_merge #(
        .OUT_FRAC_BITS(OUT_FRAC_BITS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mg_ctl),
        .i_sp    (w_sin[0]),
        .i_cp    (w_cos[0]),
        .i_sy    (w_sin[1]),
        .i_cy    (w_cos[1]),
        .i_sr    (w_sin[2]),
        .i_cr    (w_cos[2]),
        .o_vld   (o_out_valid),
        .o_res   (w_res)
    );

    assign o_forward_x = w_res[0];
    assign o_forward_y = w_res[1];
    assign o_forward_z = w_res[2];
    assign o_right_x   = w_res[3];
    assign o_right_y   = w_res[4];
    assign o_right_z   = w_res[5];
    assign o_up_x      = w_res[6];
    assign o_up_y      = w_res[7];
    assign o_up_z      = w_res[8];

endmodule

// ===== sv/eabv_chk.sv =====
// Port-level checker for the Euler-angle basis block, bound to the top level.
module eabv_chk #(
    parameter int OUT_FRAC_BITS = 14
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input logic signed [15:0]               i_pitch_angle,
    input logic signed [15:0]               i_yaw_angle,
    input logic signed [15:0]               i_roll_angle,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic signed [OUT_FRAC_BITS+1:0]  o_forward_x,
    input logic signed [OUT_FRAC_BITS+1:0]  o_forward_y,
    input logic signed [OUT_FRAC_BITS+1:0]  o_forward_z,
    input logic signed [OUT_FRAC_BITS+1:0]  o_right_x,
    input logic signed [OUT_FRAC_BITS+1:0]  o_right_y,
    input logic signed [OUT_FRAC_BITS+1:0]  o_right_z,
    input logic signed [OUT_FRAC_BITS+1:0]  o_up_x,
    input logic signed [OUT_FRAC_BITS+1:0]  o_up_y,
    input logic signed [OUT_FRAC_BITS+1:0]  o_up_z
);
    localparam int LIM = 1 << OUT_FRAC_BITS;

    // a held result keeps its value until taken (checked on forward_x, right_y and up_z)
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_forward_x)
            && $stable(o_right_y) && $stable(o_up_z))
        else $error("result changed while stalled");

    // input side only stalls while a result is waiting
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    // pipeline comes out of reset empty
    a_rst_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result present straight after reset");

    // the checked components (forward_z, up_z, right_x) stay within unity
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_forward_z <= LIM && o_forward_z >= -LIM
            && o_up_z <= LIM && o_up_z >= -LIM
            && o_right_x <= LIM && o_right_x >= -LIM)
        else $error("component outside unit range");

endmodule

bind euler_angles_to_basis_vectors eabv_chk #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_eabv_chk (.*);
